/* hdl/query_term_top_fraction_select_macros.svh */
// assertion macros for the term selector
`ifndef QUERY_TERM_TOP_FRACTION_SELECT_MACROS_SVH
`define QUERY_TERM_TOP_FRACTION_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define QTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qts check failed");
`define QTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qts check failed");
`else
`define QTS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/qts_pkg.sv */
`default_nettype none
package qts_pkg;
   localparam int ID_W    = 32;
   localparam int WT_W    = 16;
   localparam int SCORE_W = 48;
   localparam int FRAC_W  = 17;
   localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h10000;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 17'h08000;
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_DOC    = 2'd1,
      REQ_FINISH = 2'd2,
      REQ_NONE   = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_RANK,
      ST_ORDER,
      ST_PICK,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic            load;    // store id/weight into the cell at load_sel
      logic            mac;     // accumulate when the id matches
      logic            rank;    // compare scores against the circulating entry
      logic            order;   // compare ids against the circulating kept entry
      logic            shift;   // rotate the ring by one
      logic            clear;   // drop scores and counts
      logic [ID_W-1:0] id;
      logic [WT_W-1:0] wt;
   } cell_ctl_type;
endpackage
`default_nettype wire

/* hdl/qts_cell.sv */
`default_nettype none
// one slot of the term ring: holds a query term, its score, its rank and order counts
module qts_cell #(
   parameter int CNT_W = 7
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire qts_pkg::cell_ctl_type    ctl,
   input  wire                           load_sel,
   input  wire                           active,
   input  wire  [CNT_W-1:0]              keep,
   // circulating entry from the neighbor
   input  wire  [qts_pkg::ID_W-1:0]      circ_id_in,
   input  wire  [qts_pkg::SCORE_W-1:0]   circ_sc_in,
   input  wire  [CNT_W-1:0]              circ_slot_in,
   input  wire                           circ_act_in,
   input  wire                           circ_kept_in,
   output logic [qts_pkg::ID_W-1:0]      circ_id_out,
   output logic [qts_pkg::SCORE_W-1:0]   circ_sc_out,
   output logic [CNT_W-1:0]              circ_slot_out,
   output logic                          circ_act_out,
   output logic                          circ_kept_out,
   input  wire  [CNT_W-1:0]              my_slot,
   output logic [qts_pkg::ID_W-1:0]      id,
   output logic [qts_pkg::WT_W-1:0]      wt,
   output logic [CNT_W-1:0]              pos,
   output logic                          kept
);
   logic [qts_pkg::ID_W-1:0]    id_ff;
   logic [qts_pkg::WT_W-1:0]    wt_ff;
   logic [qts_pkg::SCORE_W-1:0] sc_ff, sc_in;
   logic [qts_pkg::ID_W-1:0]    cid_ff;
   logic [qts_pkg::SCORE_W-1:0] csc_ff;
   logic [CNT_W-1:0]            cslot_ff, rank_ff, pos_ff;
   logic                        cact_ff, ckept_ff;
   logic [2*qts_pkg::WT_W-1:0]  prod;
   logic [qts_pkg::SCORE_W:0]   sum;
   logic                        above;
   logic                        lower;
   logic                        kept_w;

   assign prod  = (2*qts_pkg::WT_W)'(wt_ff) * (2*qts_pkg::WT_W)'(ctl.wt);
   assign sum   = {1'b0, sc_ff} + {{(qts_pkg::SCORE_W+1-2*qts_pkg::WT_W){1'b0}}, prod};
   assign sc_in = sum[qts_pkg::SCORE_W] ? qts_pkg::SCORE_MAX : sum[qts_pkg::SCORE_W-1:0];

   // rank is final once the entry has met every other one
   assign kept_w = active && (rank_ff < keep);

   // circulating entry outranks this cell
   always_comb begin
      if (circ_sc_in != sc_ff)      above = circ_sc_in > sc_ff;
      else if (circ_id_in != id_ff) above = circ_id_in < id_ff;
      else                          above = circ_slot_in < my_slot;
   end

   // circulating entry comes earlier in the output order
   assign lower = (circ_id_in < id_ff) || (circ_id_in == id_ff && circ_slot_in < my_slot);

   always_ff @(posedge clock) begin
      if (ctl.load && load_sel) begin
         id_ff <= ctl.id;
         wt_ff <= ctl.wt;
      end
      if (ctl.clear || (ctl.load && load_sel))
         sc_ff <= '0;
      else if (ctl.mac && active && id_ff == ctl.id)
         sc_ff <= sc_in;
      if (ctl.shift) begin
         cid_ff   <= (ctl.rank || ctl.order) ? circ_id_in : id_ff;
         csc_ff   <= (ctl.rank || ctl.order) ? circ_sc_in : sc_ff;
         cslot_ff <= (ctl.rank || ctl.order) ? circ_slot_in : my_slot;
         cact_ff  <= (ctl.rank || ctl.order) ? circ_act_in : active;
         // own kept flag, seeded on the last rank step
         ckept_ff <= ctl.order ? circ_kept_in : kept_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         rank_ff <= '0;
         pos_ff  <= '0;
      end else begin
         if (ctl.rank && circ_act_in && active && above)
            rank_ff <= rank_ff + 1'b1;
         if (ctl.order && circ_kept_in && kept_w && lower)
            pos_ff <= pos_ff + 1'b1;
      end
   end

   assign circ_id_out   = cid_ff;
   assign circ_sc_out   = csc_ff;
   assign circ_slot_out = cslot_ff;
   assign circ_act_out  = cact_ff;
   assign circ_kept_out = ckept_ff;
   assign id   = id_ff;
   assign wt   = wt_ff;
   assign pos  = pos_ff;
   assign kept = kept_w;
endmodule
`default_nettype wire

/* hdl/query_term_top_fraction_select.sv */
// query term top-fraction selector
// req channel: req_valid/req_stall with req_type, term_id, term_weight.
//   load (0) stores a query term in the next free cell; loads past capacity
//   are dropped and flag overflowed. doc (1) adds query weight times doc
//   weight, saturating at 48 bits, in every cell whose id matches.
// rsp channel: rsp_valid/rsp_stall, one word per kept term in ascending id
//   order; last_term marks the final word, overflowed is the same on all.
// csr channel: csr_valid/csr_ready writes keep_fraction (q1.16, reset 0x8000).
// sequence: a load or doc word is accepted, then the cell row compares and
//   accumulates. finish is accepted, then seeds the ring, runs the rank
//   pass (every entry passes every cell) and the order pass (kept cells
//   count kept entries with lower id), then a pick and an emit state per
//   kept word, a last pick and a clear. the pick state waits while a stalled
//   word holds the rsp register. a finish with nothing to keep gives no
//   word. req_stall is high whenever the block is busy.
// reset: synchronous, clears count, overflow, cell rank and order counts, keep_fraction to 0x8000.
`default_nettype none
`include "query_term_top_fraction_select_macros.svh"
module query_term_top_fraction_select #(
   parameter int MAX_TERMS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_type,
   input  wire  [31:0] term_id,
   input  wire  [15:0] term_weight,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] kept_term_id,
   output logic [15:0] kept_weight,
   output logic        last_term,
   output logic        overflowed,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [16:0] keep_fraction
);
   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   qts_pkg::state_type        state_ff, state_in;
   qts_pkg::cell_ctl_type     ctl;
   logic [qts_pkg::FRAC_W-1:0] frac_ff;
   logic [CNT_W-1:0]          count_ff, keep_ff, step_ff, step_in, emitted_ff;
   logic                      ovf_ff;
   logic [qts_pkg::ID_W-1:0]  id_ff;
   logic [qts_pkg::WT_W-1:0]  wt_ff;
   logic [1:0]                type_ff;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_id_ff;
   logic [15:0]               rsp_wt_ff;
   logic                      rsp_last_ff, rsp_ovf_ff;

   logic [qts_pkg::ID_W-1:0]    c_id  [MAX_TERMS];
   logic [qts_pkg::WT_W-1:0]    c_wt  [MAX_TERMS];
   logic [CNT_W-1:0]            c_pos [MAX_TERMS];
   logic                        c_kept[MAX_TERMS];
   logic [qts_pkg::ID_W-1:0]    r_id  [MAX_TERMS];
   logic [qts_pkg::SCORE_W-1:0] r_sc  [MAX_TERMS];
   logic [CNT_W-1:0]            r_slot[MAX_TERMS];
   logic                        r_act [MAX_TERMS];
   logic                        r_kept[MAX_TERMS];

   logic [qts_pkg::FRAC_W-1:0]      frac_eff;
   logic [CNT_W+qts_pkg::FRAC_W-1:0] keep_prod;
   logic                            req_acc;

   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign frac_eff  = (frac_ff > qts_pkg::FRAC_ONE) ? qts_pkg::FRAC_ONE : frac_ff;
   assign keep_prod = count_ff * frac_eff;

   // ring of cells
   for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
      localparam int PREV = (g == 0) ? MAX_TERMS - 1 : g - 1;
      qts_cell #(.CNT_W(CNT_W)) u_cell (
         .clock, .reset, .ctl,
         .load_sel     (count_ff == CNT_W'(g)),
         .active       (CNT_W'(g) < count_ff),
         .keep         (keep_ff),
         .circ_id_in   (r_id[PREV]),
         .circ_sc_in   (r_sc[PREV]),
         .circ_slot_in (r_slot[PREV]),
         .circ_act_in  (r_act[PREV]),
         .circ_kept_in (r_kept[PREV]),
         .circ_id_out  (r_id[g]),
         .circ_sc_out  (r_sc[g]),
         .circ_slot_out(r_slot[g]),
         .circ_act_out (r_act[g]),
         .circ_kept_out(r_kept[g]),
         .my_slot      (CNT_W'(g)),
         .id           (c_id[g]),
         .wt           (c_wt[g]),
         .pos          (c_pos[g]),
         .kept         (c_kept[g])
      );
   end

   // the kept cell whose output position is next; at most one matches
   logic [qts_pkg::ID_W-1:0] sel_id;
   logic [qts_pkg::WT_W-1:0] sel_wt;
   always_comb begin
      sel_id = '0;
      sel_wt = '0;
      for (int i = 0; i < MAX_TERMS; i++) begin
         if (c_kept[i] && c_pos[i] == emitted_ff) begin
            sel_id = sel_id | c_id[i];
            sel_wt = sel_wt | c_wt[i];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ctl       = '0;
      ctl.id    = id_ff;
      ctl.wt    = wt_ff;
      req_stall = (state_ff != qts_pkg::ST_IDLE);
      case (state_ff)
         qts_pkg::ST_IDLE: begin
            if (req_acc) state_in = qts_pkg::ST_MAC;
         end
         qts_pkg::ST_MAC: begin
            state_in = qts_pkg::ST_IDLE;
            case (type_ff)
               qts_pkg::REQ_LOAD:
                  ctl.load = (count_ff < CNT_W'(MAX_TERMS));
               qts_pkg::REQ_DOC:
                  ctl.mac = 1'b1;
               qts_pkg::REQ_FINISH: begin
                  // seed the ring with each cell's own entry
                  ctl.shift = 1'b1;
                  step_in   = '0;
                  state_in  = qts_pkg::ST_RANK;
               end
               default: ;
            endcase
         end
         qts_pkg::ST_RANK: begin
            ctl.rank  = 1'b1;
            ctl.shift = 1'b1;
            step_in   = step_ff + 1'b1;
            // after a full turn every cell holds its own entry again
            if (step_ff == CNT_W'(MAX_TERMS - 1)) begin
               step_in  = '0;
               state_in = qts_pkg::ST_ORDER;
            end
         end
         qts_pkg::ST_ORDER: begin
            ctl.order = 1'b1;
            ctl.shift = 1'b1;
            step_in   = step_ff + 1'b1;
            if (step_ff == CNT_W'(MAX_TERMS - 1))
               state_in = qts_pkg::ST_PICK;
         end
         qts_pkg::ST_PICK: begin
            if (emitted_ff == keep_ff) state_in = qts_pkg::ST_CLEAR;
            else if (!rsp_valid_ff || !rsp_stall) state_in = qts_pkg::ST_EMIT;
         end
         qts_pkg::ST_EMIT: begin
            state_in = qts_pkg::ST_PICK;
         end
         qts_pkg::ST_CLEAR: begin
            ctl.clear = 1'b1;
            state_in  = qts_pkg::ST_IDLE;
         end
         default: state_in = qts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= qts_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (req_acc) begin
         type_ff <= req_type;
         id_ff   <= term_id;
         wt_ff   <= term_weight;
      end
      if (state_ff == qts_pkg::ST_EMIT) begin
         rsp_id_ff   <= sel_id;
         rsp_wt_ff   <= sel_wt;
         rsp_last_ff <= (emitted_ff + 1'b1 == keep_ff);
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff      <= qts_pkg::FRAC_RESET;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         keep_ff      <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) frac_ff <= keep_fraction;
         if (ctl.load) count_ff <= count_ff + 1'b1;
         if (state_ff == qts_pkg::ST_MAC && type_ff == qts_pkg::REQ_LOAD &&
             count_ff == CNT_W'(MAX_TERMS))
            ovf_ff <= 1'b1;
         if (state_ff == qts_pkg::ST_MAC && type_ff == qts_pkg::REQ_FINISH) begin
            keep_ff    <= keep_prod[CNT_W+16-1:16];
            emitted_ff <= '0;
         end
         if (state_ff == qts_pkg::ST_EMIT) emitted_ff <= emitted_ff + 1'b1;
         if (ctl.clear) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
         if (state_ff == qts_pkg::ST_EMIT) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)             rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign kept_term_id = rsp_id_ff;
   assign kept_weight  = rsp_wt_ff;
   assign last_term    = rsp_last_ff;
   assign overflowed   = rsp_ovf_ff;

   `QTS_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_TERMS))
   `QTS_ASSERT_IMPL(a_emit_bound, clock, reset, 1'b1, emitted_ff <= keep_ff)
   `QTS_ASSERT_NEXT(a_emit_valid, clock, reset, state_ff == qts_pkg::ST_EMIT, rsp_valid)
   `QTS_ASSERT_NEXT(a_clear_empty, clock, reset, state_ff == qts_pkg::ST_CLEAR,
                    count_ff == '0 && !ovf_ff)
endmodule
`default_nettype wire

/* test/query_term_top_fraction_select_tb.sv */
`default_nettype none
module query_term_top_fraction_select_tb;

   localparam int MAX_TERMS  = 64;
   // quiet time before a csr write: rank and order passes, pick/emit and the clear
   localparam int SETTLE     = 3 * MAX_TERMS + 16;
   localparam int WATCHDOG   = 5000;
   localparam int TAIL       = 300;

   typedef enum logic [1:0] {
      ENT_REQ,
      ENT_CFG,
      ENT_DRAIN
   } entry_kind_type;

   typedef struct {
      entry_kind_type        kind;
      qts_pkg::req_type_type rt;
      logic [31:0]           id;
      logic [15:0]           wt;
      logic [16:0]           frac;
   } pending_word_type;

   typedef struct {
      logic [31:0] id;
      logic [15:0] wt;
      logic        last;
      logic        ovf;
   } kept_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [31:0] term_id;
   logic [15:0] term_weight;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] kept_term_id;
   logic [15:0] kept_weight;
   logic        last_term;
   logic        overflowed;
   logic        csr_valid;
   logic        csr_ready;
   logic [16:0] keep_fraction;

   query_term_top_fraction_select #(.MAX_TERMS(MAX_TERMS)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .term_id       (term_id),
      .term_weight   (term_weight),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .kept_term_id  (kept_term_id),
      .kept_weight   (kept_weight),
      .last_term     (last_term),
      .overflowed    (overflowed),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .keep_fraction (keep_fraction)
   );

   // stimulus queue and expected kept words
   pending_word_type pending_words[$];
   kept_word_type    kept_words_due[$];

   // predictor state: one slot per stored query term
   logic [31:0] slot_id    [MAX_TERMS];
   logic [15:0] slot_wt    [MAX_TERMS];
   logic [47:0] slot_score [MAX_TERMS];
   int          slot_count;
   logic        dropped_flag;
   logic [16:0] frac_reg;

   int  mismatches;
   int  idle_cycles;     // cycles with nothing due and nothing moving
   int  quiet_cycles;    // watchdog: cycles with no handshake at all
   logic req_fire_q;
   logic csr_fire_q;
   int  gap_left;
   bit  no_gaps;
   int  stall_run;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic bit outranks(int a, int b);
      if (slot_score[a] != slot_score[b]) return slot_score[a] > slot_score[b];
      if (slot_id[a] != slot_id[b]) return slot_id[a] < slot_id[b];
      return a < b;
   endfunction

   function automatic void absorb_term(qts_pkg::req_type_type rt, logic [31:0] id,
                                       logic [15:0] wt);
      logic [48:0]  sum;
      int unsigned  frac;
      int unsigned  keep;
      int           rank;
      int           best;
      bit           kept [MAX_TERMS];
      bit           done [MAX_TERMS];
      kept_word_type w;
      case (rt)
         qts_pkg::REQ_LOAD: begin
            if (slot_count < MAX_TERMS) begin
               slot_id[slot_count] = id;
               slot_wt[slot_count] = wt;
               slot_score[slot_count] = '0;
               slot_count++;
            end else begin
               dropped_flag = 1'b1;
            end
         end
         qts_pkg::REQ_DOC: begin
            for (int i = 0; i < slot_count; i++) begin
               if (slot_id[i] == id) begin
                  sum = {1'b0, slot_score[i]} + 49'(slot_wt[i]) * 49'(wt);
                  slot_score[i] = sum[48] ? qts_pkg::SCORE_MAX : sum[47:0];
               end
            end
         end
         qts_pkg::REQ_FINISH: begin
            frac = (frac_reg > qts_pkg::FRAC_ONE) ? 32'h10000 : 32'(frac_reg);
            keep = (slot_count * frac) >> 16;
            for (int i = 0; i < slot_count; i++) begin
               rank = 0;
               for (int j = 0; j < slot_count; j++)
                  if (j != i && outranks(j, i)) rank++;
               kept[i] = rank < keep;
               done[i] = 1'b0;
            end
            // emit in ascending id, equal ids in load order
            for (int k = 0; k < keep; k++) begin
               best = -1;
               for (int i = 0; i < slot_count; i++) begin
                  if (kept[i] && !done[i] && (best < 0 || slot_id[i] < slot_id[best]))
                     best = i;
               end
               done[best] = 1'b1;
               w.id = slot_id[best];
               w.wt = slot_wt[best];
               w.last = (k + 1 == keep);
               w.ovf = dropped_flag;
               kept_words_due.push_back(w);
            end
            for (int i = 0; i < MAX_TERMS; i++) slot_score[i] = '0;
            slot_count = 0;
            dropped_flag = 1'b0;
         end
         default: ;  // unknown request is ignored
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------
   task automatic push_req(qts_pkg::req_type_type rt, logic [31:0] id, logic [15:0] wt);
      pending_word_type p;
      p.kind = ENT_REQ;
      p.rt = rt;
      p.id = id;
      p.wt = wt;
      p.frac = '0;
      pending_words.push_back(p);
   endtask

   task automatic push_ctl(entry_kind_type kind, logic [16:0] frac);
      pending_word_type p;
      p.kind = kind;
      p.rt = qts_pkg::REQ_NONE;
      p.id = '0;
      p.wt = '0;
      p.frac = frac;
      pending_words.push_back(p);
   endtask

   function automatic logic [15:0] rand_weight();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hffff;
      return 16'($urandom_range(0, 65535));
   endfunction

   // one query: loads, doc words mostly hitting stored ids with the odd unknown request, then finish
   task automatic push_query(int nload, int ndoc, bit narrow);
      logic [31:0] ids[$];
      logic [31:0] id;
      for (int k = 0; k < nload; k++) begin
         if (narrow) id = $urandom_range(0, 15);
         else if (ids.size() > 0 && $urandom_range(0, 9) == 0)
            id = ids[$urandom_range(0, ids.size() - 1)];
         else id = $urandom;
         ids.push_back(id);
         push_req(qts_pkg::REQ_LOAD, id, rand_weight());
      end
      for (int k = 0; k < ndoc; k++) begin
         if (ids.size() > 0 && $urandom_range(0, 9) < 8)
            id = ids[$urandom_range(0, ids.size() - 1)];
         else id = $urandom;
         if ($urandom_range(0, 19) == 0)
            push_req(qts_pkg::REQ_NONE, $urandom, rand_weight());
         push_req(qts_pkg::REQ_DOC, id, rand_weight());
      end
      if ($urandom_range(0, 3) == 0) push_ctl(ENT_DRAIN, '0);
      push_req(qts_pkg::REQ_FINISH, $urandom, rand_weight());
   endtask

   initial begin
      logic [16:0] frac_pick [8];
      frac_pick = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd100000,
                    17'd131071, 17'd32768, 17'd49152};

      // directed: reset fraction keeps half of five terms
      push_req(qts_pkg::REQ_LOAD, 32'h0000_0000, 16'hffff);
      push_req(qts_pkg::REQ_LOAD, 32'hffff_ffff, 16'h0000);
      push_req(qts_pkg::REQ_LOAD, 32'd5, 16'h0001);
      push_req(qts_pkg::REQ_LOAD, 32'd5, 16'h0002);           // repeated id
      push_req(qts_pkg::REQ_LOAD, 32'd7, 16'h0100);
      push_req(qts_pkg::REQ_DOC, 32'd5, 16'hffff);
      push_req(qts_pkg::REQ_DOC, 32'h0000_0000, 16'hffff);
      push_req(qts_pkg::REQ_DOC, 32'd9, 16'h1234);            // no matching query term
      push_req(qts_pkg::REQ_NONE, 32'hdead_beef, 16'hbeef);   // unknown request
      push_req(qts_pkg::REQ_FINISH, 32'd0, 16'd0);
      push_req(qts_pkg::REQ_FINISH, 32'hffff_ffff, 16'hffff); // empty query, nothing kept
      push_ctl(ENT_CFG, 17'd0);                      // nothing kept, state still clears
      push_req(qts_pkg::REQ_LOAD, 32'd3, 16'h0100);
      push_req(qts_pkg::REQ_FINISH, 32'd0, 16'd0);
      push_ctl(ENT_CFG, 17'd131071);                 // above one acts as one
      push_query(3, 3, 1'b1);
      push_ctl(ENT_CFG, 17'd65536);
      push_query(MAX_TERMS + 2, 4, 1'b0);            // loads past capacity

      // random phases across the fraction settings
      for (int ph = 0; ph < 10; ph++) begin
         if (ph < 8) push_ctl(ENT_CFG, frac_pick[ph]);
         else push_ctl(ENT_CFG, 17'($urandom_range(0, 131071)));
         push_query($urandom_range(1, 10), $urandom_range(0, 10), $urandom_range(0, 2) == 0);
      end

      // reset asserted, then released at a falling edge
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && !req_valid && !csr_valid);
      wait (kept_words_due.size() == 0);
      repeat (TAIL) @(posedge clock);
      if (mismatches == 0 && kept_words_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // driver: req and csr words, changed on the falling edge
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      logic             nv;
      logic             nc;
      logic [1:0]       nt;
      logic [31:0]      ni;
      logic [15:0]      nw;
      logic [16:0]      nf;
      pending_word_type p;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         gap_left = 0;
         no_gaps = 1'b0;
      end else begin
         nv = req_valid;
         nc = csr_valid;
         nt = req_type;
         ni = term_id;
         nw = term_weight;
         nf = keep_fraction;
         if (req_fire_q) nv = 1'b0;
         if (csr_fire_q) nc = 1'b0;
         if (!nv && !nc && pending_words.size() > 0) begin
            p = pending_words[0];
            if (p.kind == ENT_REQ) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  void'(pending_words.pop_front());
                  nv = 1'b1;
                  nt = p.rt;
                  ni = p.id;
                  nw = p.wt;
                  gap_left = pick_gap();
                  // alternate busy stretches with gapless ones per query
                  if (p.rt == qts_pkg::REQ_FINISH) no_gaps = ($urandom_range(0, 3) == 0);
               end
            end else if (kept_words_due.size() == 0 && idle_cycles >= SETTLE) begin
               // block idle: safe for a csr write or to resume after a drain
               void'(pending_words.pop_front());
               if (p.kind == ENT_CFG) begin
                  nc = 1'b1;
                  nf = p.frac;
               end
            end
         end
         req_valid <= nv;
         req_type <= nt;
         term_id <= ni;
         term_weight <= nw;
         csr_valid <= nc;
         keep_fraction <= nf;
      end
   end

   // result side back-pressure, short stalls with the odd long one
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end else begin
         rsp_stall <= 1'b1;
         stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
      end
   end

   // ---------------------------------------------------------------
   // monitor: handshakes sampled on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      logic          rf;
      logic          cf;
      logic          of;
      kept_word_type w;
      if (reset) begin
         req_fire_q <= 1'b0;
         csr_fire_q <= 1'b0;
         idle_cycles = 0;
         quiet_cycles = 0;
         slot_count = 0;
         dropped_flag = 1'b0;
         frac_reg = qts_pkg::FRAC_RESET;
         for (int i = 0; i < MAX_TERMS; i++) slot_score[i] = '0;
      end else begin
         rf = req_valid && !req_stall;
         cf = csr_valid && csr_ready;
         of = rsp_valid && !rsp_stall;
         req_fire_q <= rf;
         csr_fire_q <= cf;
         if (cf) frac_reg = keep_fraction;
         if (rf) absorb_term(qts_pkg::req_type_type'(req_type), term_id, term_weight);
         if (of) begin
            if (kept_words_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp word: id %h wt %h last %b ovf %b",
                           kept_term_id, kept_weight, last_term, overflowed);
            end else begin
               w = kept_words_due.pop_front();
               if (kept_term_id !== w.id || kept_weight !== w.wt ||
                   last_term !== w.last || overflowed !== w.ovf) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("rsp mismatch: exp id %h wt %h last %b ovf %b, ",
                            w.id, w.wt, w.last, w.ovf);
                     $display("got id %h wt %h last %b ovf %b",
                              kept_term_id, kept_weight, last_term, overflowed);
                  end
               end
            end
         end
         if (rf || cf || of || kept_words_due.size() != 0) idle_cycles = 0;
         else idle_cycles++;
         if (rf || cf || of) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // watchdog: no handshake for too long
   always @(posedge clock) begin
      if (!reset && quiet_cycles >= WATCHDOG) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      req_valid = 1'b0;
      req_type = 2'd0;
      term_id = '0;
      term_weight = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      keep_fraction = '0;
      req_fire_q = 1'b0;
      csr_fire_q = 1'b0;
      idle_cycles = 0;
      quiet_cycles = 0;
   end
endmodule
`default_nettype wire
